// ===== rtl/core/rtch_pkg.sv =====
// Shared types, constants and the multiply schedule for the closest-hit ray/triangle block.
// No dependencies; every other file in rtl/core imports this package.
package rtch_pkg;

  localparam int COORD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_TRI_DEF   = 65536;
  localparam int UV_FRAC       = 16;
  localparam int TRI_NUM_W     = 16;
  localparam int BARY_W        = 17;
  localparam int SM_W          = 33;   // edge, tvec and direction operands
  localparam int WV_W          = 67;   // cross product components
  localparam int ACC_W         = 104;  // det, u, v, t
  localparam int CHUNK_W       = 34;   // low chunk of a wide multiplier operand
  localparam int Q_W           = 33;   // quotient bits per division
  localparam int N_TERMS       = 24;
  localparam int STEP_W        = 6;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int EPS_W         = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_EPSILON = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT  = 3'd7;

  localparam logic signed [COORD_W-1:0] DIR_Z_RESET = 32'sh0001_0000;
  localparam logic [EPS_W-1:0]          EPS_RESET   = 31'd7;
  localparam logic signed [COORD_W-1:0] DIST_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] DIST_MIN    = 32'sh8000_0000;
  localparam logic [BARY_W-1:0]         BARY_ONE    = 17'h1_0000;

  // operand A kinds (small vectors)
  localparam logic [1:0] A_DIR = 2'd0;
  localparam logic [1:0] A_TV  = 2'd1;
  localparam logic [1:0] A_E1  = 2'd2;
  localparam logic [1:0] A_E2  = 2'd3;
  // operand B kinds (wide vectors)
  localparam logic [1:0] B_E2  = 2'd0;
  localparam logic [1:0] B_E1  = 2'd1;
  localparam logic [1:0] B_PV  = 2'd2;
  localparam logic [1:0] B_QV  = 2'd3;
  // scalar results
  localparam logic [1:0] SC_DET = 2'd0;
  localparam logic [1:0] SC_U   = 2'd1;
  localparam logic [1:0] SC_V   = 2'd2;
  localparam logic [1:0] SC_T   = 2'd3;

  typedef logic signed [SM_W-1:0] sm_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic                      last_triangle;
  } tri_in_t;

  typedef struct packed {
    logic                      hit;
    logic [TRI_NUM_W-1:0]      triangle_number;
    logic signed [COORD_W-1:0] distance;
    logic [BARY_W-1:0]         bary_u;
    logic [BARY_W-1:0]         bary_v;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] direction_x;
    logic signed [COORD_W-1:0] direction_y;
    logic signed [COORD_W-1:0] direction_z;
    logic [EPS_W-1:0]          det_epsilon;
    logic signed [COORD_W-1:0] distance_limit;
  } cfg_t;

  // word handed from the front to the back
  typedef struct packed {
    sm_t [2:0] e1;
    sm_t [2:0] e2;
    sm_t [2:0] tv;
    logic      last;
  } work_t;

  typedef struct packed {
    logic [1:0] a_kind;
    logic [1:0] a_idx;
    logic [1:0] b_kind;
    logic [1:0] b_idx;
    logic       neg;
    logic       first;
    logic       last;
    logic       to_scalar;
    logic [1:0] d_kind;
    logic [1:0] d_idx;
  } term_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_CHECK, S_TSTART, S_TDIV, S_UDIV, S_VDIV, S_NEXT
  } back_state_t;

  function automatic sm_t sx(input logic signed [COORD_W-1:0] x);
    return SM_W'(x);
  endfunction

  function automatic term_t mk_term(input logic [1:0] ak, input logic [1:0] ai,
                                    input logic [1:0] bk, input logic [1:0] bi,
                                    input logic ng, input logic fs, input logic ls,
                                    input logic sc, input logic [1:0] dk,
                                    input logic [1:0] di);
    term_t t;
    t.a_kind = ak; t.a_idx = ai; t.b_kind = bk; t.b_idx = bi;
    t.neg = ng; t.first = fs; t.last = ls; t.to_scalar = sc;
    t.d_kind = dk; t.d_idx = di;
    return t;
  endfunction

  // Product schedule: pv = dir x e2, qv = tv x e1, then det, u, v, t dot products.
  function automatic term_t term_of(input logic [4:0] j);
    term_t t;
    t = '0;
    case (j)
      5'd0:  t = mk_term(A_DIR, 2'd1, B_E2, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, B_PV, 2'd0);
      5'd1:  t = mk_term(A_DIR, 2'd2, B_E2, 2'd1, 1'b1, 1'b0, 1'b1, 1'b0, B_PV, 2'd0);
      5'd2:  t = mk_term(A_DIR, 2'd2, B_E2, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, B_PV, 2'd1);
      5'd3:  t = mk_term(A_DIR, 2'd0, B_E2, 2'd2, 1'b1, 1'b0, 1'b1, 1'b0, B_PV, 2'd1);
      5'd4:  t = mk_term(A_DIR, 2'd0, B_E2, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, B_PV, 2'd2);
      5'd5:  t = mk_term(A_DIR, 2'd1, B_E2, 2'd0, 1'b1, 1'b0, 1'b1, 1'b0, B_PV, 2'd2);
      5'd6:  t = mk_term(A_TV,  2'd1, B_E1, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, B_QV, 2'd0);
      5'd7:  t = mk_term(A_TV,  2'd2, B_E1, 2'd1, 1'b1, 1'b0, 1'b1, 1'b0, B_QV, 2'd0);
      5'd8:  t = mk_term(A_TV,  2'd2, B_E1, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, B_QV, 2'd1);
      5'd9:  t = mk_term(A_TV,  2'd0, B_E1, 2'd2, 1'b1, 1'b0, 1'b1, 1'b0, B_QV, 2'd1);
      5'd10: t = mk_term(A_TV,  2'd0, B_E1, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, B_QV, 2'd2);
      5'd11: t = mk_term(A_TV,  2'd1, B_E1, 2'd0, 1'b1, 1'b0, 1'b1, 1'b0, B_QV, 2'd2);
      5'd12: t = mk_term(A_E1,  2'd0, B_PV, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, SC_DET, 2'd0);
      5'd13: t = mk_term(A_E1,  2'd1, B_PV, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, SC_DET, 2'd0);
      5'd14: t = mk_term(A_E1,  2'd2, B_PV, 2'd2, 1'b0, 1'b0, 1'b1, 1'b1, SC_DET, 2'd0);
      5'd15: t = mk_term(A_TV,  2'd0, B_PV, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, SC_U, 2'd0);
      5'd16: t = mk_term(A_TV,  2'd1, B_PV, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, SC_U, 2'd0);
      5'd17: t = mk_term(A_TV,  2'd2, B_PV, 2'd2, 1'b0, 1'b0, 1'b1, 1'b1, SC_U, 2'd0);
      5'd18: t = mk_term(A_DIR, 2'd0, B_QV, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, SC_V, 2'd0);
      5'd19: t = mk_term(A_DIR, 2'd1, B_QV, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, SC_V, 2'd0);
      5'd20: t = mk_term(A_DIR, 2'd2, B_QV, 2'd2, 1'b0, 1'b0, 1'b1, 1'b1, SC_V, 2'd0);
      5'd21: t = mk_term(A_E2,  2'd0, B_QV, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, SC_T, 2'd0);
      5'd22: t = mk_term(A_E2,  2'd1, B_QV, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, SC_T, 2'd0);
      5'd23: t = mk_term(A_E2,  2'd2, B_QV, 2'd2, 1'b0, 1'b0, 1'b1, 1'b1, SC_T, 2'd0);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/rtch_front.sv =====
// Front stage: accepts triangle words and forms edges and the origin offset.
// Depends on rtch_pkg.
module rtch_front import rtch_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  tri_in_t in_data,
  output logic    push_valid,
  input  logic    push_ready,
  output work_t   push_data
);

  work_t word_next;

  assign in_ready = !push_valid || push_ready;

  always_comb begin
    word_next.e1[0] = sx(in_data.v1_x) - sx(in_data.v0_x);
    word_next.e1[1] = sx(in_data.v1_y) - sx(in_data.v0_y);
    word_next.e1[2] = sx(in_data.v1_z) - sx(in_data.v0_z);
    word_next.e2[0] = sx(in_data.v2_x) - sx(in_data.v0_x);
    word_next.e2[1] = sx(in_data.v2_y) - sx(in_data.v0_y);
    word_next.e2[2] = sx(in_data.v2_z) - sx(in_data.v0_z);
    word_next.tv[0] = sx(cfg.origin_x) - sx(in_data.v0_x);
    word_next.tv[1] = sx(cfg.origin_y) - sx(in_data.v0_y);
    word_next.tv[2] = sx(cfg.origin_z) - sx(in_data.v0_z);
    word_next.last  = in_data.last_triangle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else if (in_ready) begin
      push_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      push_data <= word_next;
    end
  end

endmodule

// ===== rtl/core/rtch_queue.sv =====
// Short FIFO between the front and the back.
// Depends on rtch_pkg.
module rtch_queue import rtch_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop,
  output work_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rtch_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rtch_pkg.
module rtch_div import rtch_pkg::*; #(
  parameter int NUM_W = ACC_W + UV_FRAC,
  parameter int DEN_W = ACC_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W:0]   rem;
  logic [Q_W-1:0]   low_bits;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             take;

  // upper numerator bits must already be below the divisor
  assign trial = {rem[DEN_W-1:0], low_bits[Q_W-1]};
  assign take  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {{(DEN_W + 1 - HI_W){1'b0}}, num[NUM_W-1:Q_W]};
      low_bits <= num[Q_W-1:0];
      den_r    <= den;
    end else if (busy) begin
      rem      <= take ? trial - {1'b0, den_r} : trial;
      low_bits <= {low_bits[Q_W-2:0], 1'b0};
      quo      <= {quo[Q_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/rtch_back.sv =====
// Back end: shared multiply-accumulate sequencer, hit test, divisions and closest-hit state.
// Depends on rtch_pkg and rtch_div.
module rtch_back import rtch_pkg::*; #(
  parameter int COORD_FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_TRIANGLES   = MAX_TRI_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      lim_we,
  input  logic signed [COORD_W-1:0] lim_value,
  input  logic                      q_valid,
  input  work_t                     q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output result_t                   out_data
);

  localparam int CNT_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int NUM_X = (COORD_FRAC_BITS > UV_FRAC) ? COORD_FRAC_BITS : UV_FRAC;
  localparam int NUM_W = ACC_W + NUM_X;
  localparam int CMP_W = ACC_W + Q_W;
  localparam int MUL_W = SM_W + CHUNK_W + 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * N_TERMS - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_TRIANGLES - 1);

  back_state_t state, state_next;

  sm_t                     sv [4][3];
  logic signed [WV_W-1:0]  wv [4][3];
  logic signed [ACC_W-1:0] sc [4];
  logic                    work_last;
  logic [STEP_W-1:0]       step;

  term_t                    cur;
  sm_t                      a_op;
  logic signed [WV_W-1:0]   b_w;
  logic signed [CHUNK_W:0]  b_op;
  logic signed [MUL_W-1:0]  mul;

  logic signed [MUL_W-1:0]  prod;
  logic                     p_valid, p_hi, p_neg, p_first, p_last, p_scalar;
  logic [1:0]               p_dk, p_di;
  logic signed [ACC_W-1:0]  acc, addend, acc_base, acc_sum;

  logic signed [ACC_W-1:0]  det_s, u_s, v_s, t_s, eps_w, uv_sum;
  logic                     pass;
  logic                     tneg, sat_big;
  logic [ACC_W-1:0]         mag;
  logic [CMP_W-1:0]         mag_ext, det_shift;

  logic                     div_start, div_done;
  logic [1:0]               div_sel;
  logic [NUM_W-1:0]         div_num;
  logic [Q_W-1:0]           div_q;
  logic                     q_pos_ovf, q_neg_ovf;
  logic signed [COORD_W-1:0] hit_dist;
  logic                     closer;

  logic signed [COORD_W-1:0] best_distance;
  logic [BARY_W-1:0]         best_u, best_v;
  logic [TRI_NUM_W-1:0]      best_number;
  logic                      any_hit;
  logic [CNT_W-1:0]          counter;
  logic [CNT_W+TRI_NUM_W-1:0] cnt_ext;
  logic [TRI_NUM_W-1:0]      number;

  logic issue, emit, advance;

  // ---- multiplier issue ----
  assign cur  = term_of(step[STEP_W-1:1]);
  assign a_op = sv[cur.a_kind][cur.a_idx];
  assign b_w  = wv[cur.b_kind][cur.b_idx];
  assign b_op = step[0] ? (CHUNK_W + 1)'($signed(b_w[WV_W-1:CHUNK_W]))
                        : $signed({1'b0, b_w[CHUNK_W-1:0]});
  assign mul  = a_op * b_op;

  // ---- accumulate ----
  assign addend   = p_hi ? (ACC_W'(prod) <<< CHUNK_W) : ACC_W'(prod);
  assign acc_base = p_first ? '0 : acc;
  assign acc_sum  = p_neg ? acc_base - addend : acc_base + addend;

  // ---- hit test ----
  assign det_s  = sc[SC_DET];
  assign u_s    = sc[SC_U];
  assign v_s    = sc[SC_V];
  assign t_s    = sc[SC_T];
  assign eps_w  = $signed({{(ACC_W - EPS_W){1'b0}}, cfg.det_epsilon} << (2 * COORD_FRAC_BITS));
  assign uv_sum = u_s + v_s;
  assign pass   = !det_s[ACC_W-1] && (det_s != '0) && !(det_s < eps_w) &&
                  !u_s[ACC_W-1] && !(det_s < u_s) &&
                  !v_s[ACC_W-1] && !(det_s < uv_sum);

  // distance overflows when mag << frac reaches det << Q_W
  assign mag_ext   = CMP_W'(mag);
  assign det_shift = CMP_W'(det_s) << (Q_W - COORD_FRAC_BITS);

  always_comb begin
    case (div_sel)
      2'd1:    div_num = {{(NUM_W - ACC_W){1'b0}}, u_s} << UV_FRAC;
      2'd2:    div_num = {{(NUM_W - ACC_W){1'b0}}, v_s} << UV_FRAC;
      default: div_num = {{(NUM_W - ACC_W){1'b0}}, mag} << COORD_FRAC_BITS;
    endcase
  end

  rtch_div #(
    .NUM_W (NUM_W),
    .DEN_W (ACC_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det_s),
    .done  (div_done),
    .quo   (div_q)
  );

  assign q_pos_ovf = div_q[Q_W-1] | div_q[Q_W-2];
  assign q_neg_ovf = div_q[Q_W-1] | (div_q[Q_W-2] & (|div_q[Q_W-3:0]));

  always_comb begin
    if (tneg) begin
      hit_dist = (sat_big || q_neg_ovf) ? DIST_MIN : -$signed(div_q[COORD_W-1:0]);
    end else begin
      hit_dist = (sat_big || q_pos_ovf) ? DIST_MAX : $signed(div_q[COORD_W-1:0]);
    end
  end

  assign closer  = (hit_dist < best_distance);
  assign cnt_ext = {{TRI_NUM_W{1'b0}}, counter};
  assign number  = cnt_ext[TRI_NUM_W-1:0];

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    issue      = 1'b0;
    div_start  = 1'b0;
    div_sel    = 2'd0;
    emit       = 1'b0;
    advance    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        issue = 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_CHECK;
      S_CHECK:  state_next = pass ? S_TSTART : S_NEXT;
      S_TSTART: begin
        div_start  = 1'b1;
        state_next = S_TDIV;
      end
      S_TDIV: begin
        if (div_done) begin
          if (closer) begin
            div_start  = 1'b1;
            div_sel    = 2'd1;
            state_next = S_UDIV;
          end else begin
            state_next = S_NEXT;
          end
        end
      end
      S_UDIV: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_sel    = 2'd2;
          state_next = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_done) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!work_last) begin
          advance    = 1'b1;
          state_next = S_IDLE;
        end else if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        sv[A_TV][i] <= q_data.tv[i];
        sv[A_E1][i] <= q_data.e1[i];
        sv[A_E2][i] <= q_data.e2[i];
        wv[B_E1][i] <= WV_W'($signed(q_data.e1[i]));
        wv[B_E2][i] <= WV_W'($signed(q_data.e2[i]));
      end
      sv[A_DIR][0] <= sx(cfg.direction_x);
      sv[A_DIR][1] <= sx(cfg.direction_y);
      sv[A_DIR][2] <= sx(cfg.direction_z);
      work_last    <= q_data.last;
      step         <= '0;
    end else if (issue) begin
      step <= step + 1'b1;
    end
    if (issue) begin
      prod     <= mul;
      p_hi     <= step[0];
      p_neg    <= cur.neg;
      p_first  <= cur.first && !step[0];
      p_last   <= cur.last && step[0];
      p_scalar <= cur.to_scalar;
      p_dk     <= cur.d_kind;
      p_di     <= cur.d_idx;
    end
    if (p_valid) begin
      acc <= acc_sum;
      if (p_last) begin
        if (p_scalar) begin
          sc[p_dk] <= acc_sum;
        end else begin
          wv[p_dk][p_di] <= acc_sum[WV_W-1:0];
        end
      end
    end
    if (state == S_CHECK) begin
      tneg <= t_s[ACC_W-1];
      mag  <= t_s[ACC_W-1] ? ACC_W'(-t_s) : ACC_W'(t_s);
    end
    if (state == S_TSTART) begin
      sat_big <= (mag_ext >= det_shift);
    end
    if (emit) begin
      out_data.hit             <= any_hit;
      out_data.triangle_number <= any_hit ? best_number : '0;
      out_data.distance        <= any_hit ? best_distance : '0;
      out_data.bary_u          <= any_hit ? best_u : '0;
      out_data.bary_v          <= any_hit ? best_v : '0;
    end
  end

  // ---- closest-hit state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid       <= 1'b0;
      out_valid     <= 1'b0;
      best_distance <= DIST_MAX;
      best_u        <= '0;
      best_v        <= '0;
      best_number   <= '0;
      any_hit       <= 1'b0;
      counter       <= '0;
    end else begin
      p_valid <= issue;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (lim_we && counter == '0) begin
        best_distance <= lim_value;
      end
      if (state == S_TDIV && div_done) begin
        any_hit <= 1'b1;
        if (closer) begin
          best_distance <= hit_dist;
          best_number   <= number;
        end
      end
      if (state == S_UDIV && div_done) begin
        best_u <= div_q[BARY_W-1:0];
      end
      if (state == S_VDIV && div_done) begin
        best_v <= div_q[BARY_W-1:0];
      end
      if (advance) begin
        counter <= (counter == CNT_LAST) ? '0 : counter + 1'b1;
      end
      if (emit) begin
        best_distance <= cfg.distance_limit;
        best_u        <= '0;
        best_v        <= '0;
        best_number   <= '0;
        any_hit       <= 1'b0;
        counter       <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_TDIV || state == S_UDIV || state == S_VDIV))
    else $error("divider finished outside a division wait");

  a_mesh_cleared: assert property (@(posedge clk) disable iff (rst)
    emit |=> (!any_hit && counter == '0 && out_valid))
    else $error("mesh state not cleared after result");

  a_bary_range: assert property (@(posedge clk) disable iff (rst)
    (best_u <= BARY_ONE) && (best_v <= BARY_ONE))
    else $error("barycentric out of range");

  a_no_hit_clean: assert property (@(posedge clk) disable iff (rst)
    !any_hit |-> (best_number == '0 && best_u == '0 && best_v == '0))
    else $error("closest-hit fields set without a hit");
`endif

endmodule

// ===== rtl/core/ray_triangle_closest_hit.sv =====
// Closest-hit ray/triangle intersection, single sided, fixed point.
// Each triangle makes 48 passes through the shared 33x35 multiplier, then a hit adds the
// distance division and a closer hit the u and v divisions; the back end takes a new
// triangle from the queue only when it is through with the last one.
// Reset is synchronous: the registers that have reset values return to them; there is no clearing pass.
// Depends on rtch_pkg, rtch_front, rtch_queue, rtch_back.
module ray_triangle_closest_hit import rtch_pkg::*; #(
  parameter int COORD_FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_TRIANGLES   = MAX_TRI_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tri_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data
);

  cfg_t  cfg;
  logic  push_valid, push_ready, q_valid, q_pop, lim_we;
  work_t push_data, q_data;

  assign lim_we = cfg_we && (cfg_index == CFG_DIST_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x       <= '0;
      cfg.origin_y       <= '0;
      cfg.origin_z       <= '0;
      cfg.direction_x    <= '0;
      cfg.direction_y    <= '0;
      cfg.direction_z    <= DIR_Z_RESET;
      cfg.det_epsilon    <= EPS_RESET;
      cfg.distance_limit <= DIST_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:    cfg.origin_x       <= $signed(cfg_data);
        CFG_ORIGIN_Y:    cfg.origin_y       <= $signed(cfg_data);
        CFG_ORIGIN_Z:    cfg.origin_z       <= $signed(cfg_data);
        CFG_DIRECTION_X: cfg.direction_x    <= $signed(cfg_data);
        CFG_DIRECTION_Y: cfg.direction_y    <= $signed(cfg_data);
        CFG_DIRECTION_Z: cfg.direction_z    <= $signed(cfg_data);
        CFG_DET_EPSILON: cfg.det_epsilon    <= cfg_data[EPS_W-1:0];
        CFG_DIST_LIMIT:  cfg.distance_limit <= $signed(cfg_data);
        default:         cfg.origin_x       <= cfg.origin_x;
      endcase
    end
  end

  rtch_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rtch_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  rtch_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .MAX_TRIANGLES   (MAX_TRIANGLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .lim_we    (lim_we),
    .lim_value ($signed(cfg_data)),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/rtch_checker.sv =====
// Checker for ray_triangle_closest_hit: watches config, triangle and result words.
// It predicts the closest-hit result of each mesh and compares it field by field.
// Depends on rtch_pkg.
`timescale 1ns / 100ps

module rtch_checker import rtch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  tri_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  result_t              out_data,
  output int                   errors,
  output int                   pending
);

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec3_t [3];

  cfg_t              ray;
  logic signed [31:0] best_dist;
  logic [BARY_W-1:0] best_u, best_v;
  logic [15:0]       best_num;
  logic              any_hit;
  logic [15:0]       tri_count;
  result_t           mesh_results [$];

  assign pending = mesh_results.size();

  function automatic wide_t ext(input logic signed [31:0] x);
    return wide_t'(x);
  endfunction

  function automatic vec3_t cross3(input vec3_t a, input vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  function automatic wide_t dot(input vec3_t a, input vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d);
    return n / d;
  endfunction

  function automatic void restart_mesh();
    best_dist = ray.distance_limit;
    best_u    = '0;
    best_v    = '0;
    best_num  = '0;
    any_hit   = 1'b0;
    tri_count = '0;
  endfunction

  // one triangle through the single-sided test; returns 1 when the mesh ends
  function automatic bit trace_triangle(input tri_in_t tri_w, output result_t res);
    vec3_t e1, e2, tv, dir, pv, qv;
    wide_t det, u, v, t, eps, mag;
    logic [127:0] q;
    logic signed [31:0] hit_dist;
    logic signed [31:0] vx [3], wx [3], zx [3], ox [3], dx [3];
    bit ok;
    vx = '{tri_w.v0_x, tri_w.v0_y, tri_w.v0_z};
    wx = '{tri_w.v1_x, tri_w.v1_y, tri_w.v1_z};
    zx = '{tri_w.v2_x, tri_w.v2_y, tri_w.v2_z};
    ox = '{ray.origin_x, ray.origin_y, ray.origin_z};
    dx = '{ray.direction_x, ray.direction_y, ray.direction_z};
    for (int i = 0; i < 3; i++) begin
      e1[i]  = ext(wx[i]) - ext(vx[i]);
      e2[i]  = ext(zx[i]) - ext(vx[i]);
      tv[i]  = ext(ox[i]) - ext(vx[i]);
      dir[i] = ext(dx[i]);
    end
    pv  = cross3(dir, e2);
    det = dot(e1, pv);
    eps = wide_t'({97'd0, ray.det_epsilon}) <<< 32;
    ok  = !(det <= 0 || det < eps);
    u   = dot(tv, pv);
    if (ok && (u < 0 || det < u)) ok = 0;
    qv  = cross3(tv, e1);
    v   = dot(dir, qv);
    if (ok && (v < 0 || det < u + v)) ok = 0;
    if (ok) begin
      t   = dot(e2, qv);
      mag = (t < 0) ? -t : t;
      q   = udiv(mag <<< 16, det);
      if (t < 0) hit_dist = (q > 128'h8000_0000) ? DIST_MIN : -$signed(q[31:0]);
      else       hit_dist = (q > 128'h7FFF_FFFF) ? DIST_MAX : $signed(q[31:0]);
      any_hit = 1'b1;
      if (hit_dist < best_dist) begin
        best_dist = hit_dist;
        best_u    = BARY_W'(udiv(u <<< 16, det));
        best_v    = BARY_W'(udiv(v <<< 16, det));
        best_num  = tri_count;
      end
    end
    res = '0;
    if (!tri_w.last_triangle) begin
      tri_count++;
      return 0;
    end
    if (any_hit) begin
      res.hit             = 1'b1;
      res.triangle_number = best_num;
      res.distance        = best_dist;
      res.bary_u          = best_u;
      res.bary_v          = best_v;
    end
    restart_mesh();
    return 1;
  endfunction

  always @(posedge clk) begin
    result_t r, want;
    if (rst) begin
      ray = '0;
      ray.direction_z    = DIR_Z_RESET;
      ray.det_epsilon    = EPS_RESET;
      ray.distance_limit = DIST_MAX;
      restart_mesh();
      mesh_results.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X:    ray.origin_x = cfg_data;
          CFG_ORIGIN_Y:    ray.origin_y = cfg_data;
          CFG_ORIGIN_Z:    ray.origin_z = cfg_data;
          CFG_DIRECTION_X: ray.direction_x = cfg_data;
          CFG_DIRECTION_Y: ray.direction_y = cfg_data;
          CFG_DIRECTION_Z: ray.direction_z = cfg_data;
          CFG_DET_EPSILON: ray.det_epsilon = cfg_data[EPS_W-1:0];
          CFG_DIST_LIMIT: begin
            ray.distance_limit = cfg_data;
            if (tri_count == 0) best_dist = cfg_data;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready && trace_triangle(in_data, r)) mesh_results.push_back(r);
      if (out_valid && out_ready) begin
        if (mesh_results.size() == 0) begin
          if (errors < 10) $display("unexpected result word %p", out_data);
          errors <= errors + 1;
        end else begin
          want = mesh_results.pop_front();
          if (want.hit !== out_data.hit || want.triangle_number !== out_data.triangle_number ||
              want.distance !== out_data.distance || want.bary_u !== out_data.bary_u ||
              want.bary_v !== out_data.bary_v) begin
            if (errors < 10) $display("mismatch: expected %p got %p", want, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_ray_triangle_closest_hit.sv =====
// Top of the ray_triangle_closest_hit testbench: clock, reset, config phases, triangle
// stimulus and the verdict. Depends on rtch_pkg, the block and rtch_checker.
`timescale 1ns / 100ps

module tb_ray_triangle_closest_hit import rtch_pkg::*;;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 1500000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ORIGIN_X;
  logic [COORD_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tri_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_data;
  int                   errors, pending;
  int                   cycles = 0;
  bit                   busy_phase = 1'b1;
  bit                   took = 1'b0;
  int                   stall = 0;
  cfg_t                 ray;

  always #4 clk = ~clk;

  ray_triangle_closest_hit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rtch_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    took   <= out_valid && out_ready;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: fresh stall after every accepted word
  always @(negedge clk) begin
    int s;
    s = stall;
    if (took) s = busy_phase ? $urandom_range(0, 13) : 0;
    if (rst) out_ready <= 1'b0;
    else if (s > 0) begin
      out_ready <= 1'b0;
      s--;
    end else out_ready <= 1'b1;
    stall = s;
  end

  function automatic int gap();
    return busy_phase ? $urandom_range(0, 13) : 0;
  endfunction

  // called right after a rising edge; leaves after the word is taken
  task automatic send(input tri_in_t w);
    int g;
    g = gap();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_ray(input cfg_t c);
    write_reg(CFG_ORIGIN_X, c.origin_x);
    write_reg(CFG_ORIGIN_Y, c.origin_y);
    write_reg(CFG_ORIGIN_Z, c.origin_z);
    write_reg(CFG_DIRECTION_X, c.direction_x);
    write_reg(CFG_DIRECTION_Y, c.direction_y);
    write_reg(CFG_DIRECTION_Z, c.direction_z);
    write_reg(CFG_DET_EPSILON, {1'b0, c.det_epsilon});
    write_reg(CFG_DIST_LIMIT, c.distance_limit);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    ray = c;
  endtask

  function automatic tri_in_t make_tri(input int x0, y0, z0, x1, y1, z1, x2, y2, z2,
                                       input bit last);
    tri_in_t w;
    w = '{x0, y0, z0, x1, y1, z1, x2, y2, z2, last};
    return w;
  endfunction

  // triangle placed around a point on the ray, or plain noise
  function automatic tri_in_t random_tri(input bit last);
    tri_in_t w;
    int s, r, px, py, pz;
    logic [31:0] c [9];
    if ($urandom_range(0, 9) < 7) begin
      s  = $urandom_range(0, 12);
      px = ray.origin_x + ray.direction_x / 4 * s;
      py = ray.origin_y + ray.direction_y / 4 * s;
      pz = ray.origin_z + ray.direction_z / 4 * s;
      r  = 1 << $urandom_range(10, 19);
      for (int i = 0; i < 3; i++) begin
        c[3*i]   = px + $signed($urandom_range(0, 2*r)) - r;
        c[3*i+1] = py + $signed($urandom_range(0, 2*r)) - r;
        c[3*i+2] = pz + $signed($urandom_range(0, 2*r)) - r;
      end
    end else begin
      for (int i = 0; i < 9; i++) c[i] = $urandom();
    end
    w = '{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], last};
    return w;
  endfunction

  function automatic cfg_t random_ray(input int style);
    cfg_t c;
    c.origin_x = $signed($urandom_range(0, 8*ONE)) - 4*ONE;
    c.origin_y = $signed($urandom_range(0, 8*ONE)) - 4*ONE;
    c.origin_z = $signed($urandom_range(0, 8*ONE)) - 4*ONE;
    c.direction_x = $signed($urandom_range(0, 2*ONE)) - ONE;
    c.direction_y = $signed($urandom_range(0, 2*ONE)) - ONE;
    c.direction_z = $signed($urandom_range(0, 2*ONE)) - ONE;
    c.det_epsilon = EPS_W'($urandom_range(0, 64));
    c.distance_limit = $urandom_range(0, 12 * ONE);
    case (style)
      1: begin
        c.det_epsilon = '0;
        c.distance_limit = DIST_MIN;
      end
      2: begin
        c = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              EPS_W'($urandom()), $urandom()};
      end
      3: begin
        c.det_epsilon = 31'h7FFF_FFFF;
        c.distance_limit = DIST_MAX;
      end
      4: begin
        c.direction_x = DIST_MAX;
        c.direction_y = DIST_MIN;
        c.distance_limit = DIST_MAX;
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    tri_in_t w;
    int left;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset ray: origin 0, direction +z
    ray = '0;
    ray.direction_z = DIR_Z_RESET;
    ray.det_epsilon = EPS_RESET;
    ray.distance_limit = DIST_MAX;
    send(make_tri(-ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, 0));
    send(make_tri(-ONE, -ONE, 3*ONE, -ONE, ONE, 3*ONE, 2*ONE, -ONE, 3*ONE, 0));
    // same triangle again: a tie keeps the first one
    send(make_tri(-ONE, -ONE, 3*ONE, -ONE, ONE, 3*ONE, 2*ONE, -ONE, 3*ONE, 0));
    // back face
    send(make_tri(-ONE, -ONE, 2*ONE, 2*ONE, -ONE, 2*ONE, -ONE, ONE, 2*ONE, 0));
    // degenerate, zero determinant
    send(make_tri(0, 0, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, ONE, 0));
    // behind the origin, negative distance wins
    send(make_tri(-ONE, -ONE, -ONE, -ONE, ONE, -ONE, ONE, -ONE, -ONE, 1));
    // ray exactly on an edge, then a miss-only mesh
    send(make_tri(-ONE, -ONE, ONE, -ONE, ONE, ONE, ONE, -ONE, ONE, 1));
    send(make_tri(5*ONE, 5*ONE, ONE, 5*ONE, 6*ONE, ONE, 6*ONE, 5*ONE, ONE, 1));
    send(make_tri(DIST_MIN, DIST_MIN, DIST_MIN, DIST_MAX, DIST_MAX, DIST_MAX,
                  DIST_MIN, DIST_MAX, 0, 1));
    send(make_tri(DIST_MAX, DIST_MIN, DIST_MAX, DIST_MIN, DIST_MAX, DIST_MIN,
                  DIST_MAX, DIST_MIN, -1, 1));
    send(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1));
    // the sender holds off until every result is in
    settle();

    // hit with every distance beyond the limit
    load_ray(random_ray(1));
    send(make_tri(-ONE, -ONE, ray.origin_z + ONE, -ONE, ONE, ray.origin_z + ONE,
                  2*ONE, -ONE, ray.origin_z + ONE, 1));
    for (int p = 0; p < 9; p++) begin
      if (p > 0) begin
        settle();
        load_ray(random_ray(p % 5));
      end
      busy_phase = (p % 3 != 2);
      left = 0;
      for (int k = 0; k < 115; k++) begin
        if (left == 0) left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20)
                                                          : $urandom_range(1, 5);
        left--;
        send(random_tri(left == 0 || k == 114));
      end
    end
    settle();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
